### rtl/fr_pkg.sv
`timescale 1ns / 1ps

package fr_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NEG_DEN  = 2'd1,
    STAT_ZERO_DEN = 2'd2
  } status_e;

  // Classification handed from front to back with each queued item
  typedef struct packed {
    status_e status;
    logic    neg;
  } fr_cls_t;

  // Back-end sequencer states
  typedef enum logic [4:0] {
    CS_IDLE = 5'b00001,
    CS_GCD  = 5'b00010,
    CS_DIVN = 5'b00100,
    CS_DIVD = 5'b01000,
    CS_DONE = 5'b10000
  } core_state_e;

endpackage

### rtl/fr_front.sv
`timescale 1ns / 1ps

module fr_front #(
  parameter int unsigned W = 32
) (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [W-1:0]    num_i,
  input  logic [W-1:0]    den_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output fr_pkg::fr_cls_t cls_o,
  output logic [W-1:0]    mag_o,
  output logic [W-2:0]    den_o
);
  import fr_pkg::*;

  localparam logic [W-1:0] ONE = W'(1);

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  always_comb begin
    if (den_i[W-1]) begin
      cls_o.status = STAT_NEG_DEN;
    end else if (den_i == '0) begin
      cls_o.status = STAT_ZERO_DEN;
    end else begin
      cls_o.status = STAT_OK;
    end
    cls_o.neg = num_i[W-1];
  end

  // Magnitude of the most negative value fits W bits unsigned
  assign mag_o = num_i[W-1] ? (~num_i + ONE) : num_i;
  assign den_o = den_i[W-2:0];

endmodule

### rtl/fr_fifo.sv
`timescale 1ns / 1ps

module fr_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);
  import fr_pkg::*;

  localparam logic [1:0] FULL = 2'd2;

  logic [DW-1:0] mem_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count out of range");

  a_wr_rd_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == FULL) |-> wr_q == rd_q)
    else $error("queue pointers disagree with count");

  a_one_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> wr_q != rd_q)
    else $error("queue pointers disagree with single entry");

endmodule

### rtl/fr_div.sv
`timescale 1ns / 1ps

module fr_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);
  import fr_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dsr_q, dsr_d;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = !diff[W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider started while busy");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dsr_q)
    else $error("divider remainder not below divisor");

endmodule

### rtl/fr_core.sv
`timescale 1ns / 1ps

module fr_core #(
  parameter int unsigned W = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  fr_pkg::fr_cls_t pop_cls_i,
  input  logic [W-1:0]    pop_mag_i,
  input  logic [W-2:0]    pop_den_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fr_pkg::status_e status_o,
  output logic [W-1:0]    red_num_o,
  output logic [W-2:0]    red_den_o,
  output logic            whole_o
);
  import fr_pkg::*;

  localparam int unsigned  KW      = $clog2(W);
  localparam logic [W-1:0] ONE     = W'(1);
  localparam logic [W-2:0] DEN_ONE = (W-1)'(1);

  core_state_e   state_q, state_d;
  logic          start_q, start_d;
  logic          out_valid_q, out_valid_d;
  fr_cls_t       cls_q, cls_d;
  logic [W-1:0]  mag_q, mag_d;
  logic [W-2:0]  den_q, den_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [W-1:0]  g_q, g_d;
  logic [W-1:0]  qn_q, qn_d;
  logic [W-1:0]  qd_q, qd_d;
  status_e       status_q, status_d;
  logic [W-1:0]  red_num_q, red_num_d;
  logic [W-2:0]  red_den_q, red_den_d;
  logic          whole_q, whole_d;

  logic [W:0]    ab_diff;
  logic [W-1:0]  ab_abs;
  logic          out_load;
  logic [W-1:0]  div_dvd;
  logic          div_done;
  logic [W-1:0]  div_quo;

  // Shared divider: numerator magnitude first, then the denominator
  assign div_dvd = (state_q == CS_DIVD) ? {1'b0, den_q} : mag_q;

  fr_div #(.W(W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (div_dvd),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign ab_diff = {1'b0, a_q} - {1'b0, b_q};
  assign ab_abs  = ab_diff[W] ? (~ab_diff[W-1:0] + ONE) : ab_diff[W-1:0];

  assign pop_ready_o = (state_q == CS_IDLE);
  assign out_load    = (state_q == CS_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    cls_d       = cls_q;
    mag_d       = mag_q;
    den_d       = den_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    g_d         = g_q;
    qn_d        = qn_q;
    qd_d        = qd_q;
    status_d    = status_q;
    red_num_d   = red_num_q;
    red_den_d   = red_den_q;
    whole_d     = whole_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    case (state_q)
      CS_IDLE: begin
        if (pop_valid_i) begin
          cls_d = pop_cls_i;
          mag_d = pop_mag_i;
          den_d = pop_den_i;
          a_d   = pop_mag_i;
          b_d   = {1'b0, pop_den_i};
          k_d   = '0;
          state_d = (pop_cls_i.status == STAT_OK) ? CS_GCD : CS_DONE;
        end
      end
      CS_GCD: begin
        // Binary gcd, one step a cycle
        if (a_q == '0) begin
          g_d     = b_q << k_q;
          start_d = 1'b1;
          state_d = CS_DIVN;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!ab_diff[W]) begin
          a_d = ab_abs;
        end else begin
          b_d = ab_abs;
        end
      end
      CS_DIVN: begin
        if (div_done) begin
          qn_d    = div_quo;
          start_d = 1'b1;
          state_d = CS_DIVD;
        end
      end
      CS_DIVD: begin
        if (div_done) begin
          qd_d    = div_quo;
          state_d = CS_DONE;
        end
      end
      CS_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          status_d    = cls_q.status;
          if (cls_q.status == STAT_OK) begin
            red_num_d = cls_q.neg ? (~qn_q + ONE) : qn_q;
            red_den_d = qd_q[W-2:0];
            whole_d   = (qd_q == ONE);
          end else begin
            red_num_d = '0;
            red_den_d = '0;
            whole_d   = 1'b0;
          end
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q     <= cls_d;
    mag_q     <= mag_d;
    den_q     <= den_d;
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    g_q       <= g_d;
    qn_q      <= qn_d;
    qd_q      <= qd_d;
    status_q  <= status_d;
    red_num_q <= red_num_d;
    red_den_q <= red_den_d;
    whole_q   <= whole_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign red_num_o   = red_num_q;
  assign red_den_o   = red_den_q;
  assign whole_o     = whole_q;

  a_gcd_b_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_GCD |-> b_q != '0)
    else $error("gcd operand b reached zero");

  a_start_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (state_q == CS_DIVN || state_q == CS_DIVD))
    else $error("divider started outside a divide state");

  a_err_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STAT_OK) |->
      (red_num_q == '0 && red_den_q == '0 && !whole_q))
    else $error("refused item carries nonzero fields");

  a_whole_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && whole_q) |-> red_den_q == DEN_ONE)
    else $error("whole flag without unit denominator");

endmodule

### rtl/fraction_reducer.sv
`timescale 1ns / 1ps

// Reduces one signed fraction to lowest terms. Each input beat carries a
// two's complement numerator and denominator and yields exactly one output
// beat. A negative denominator returns status 1 and a zero denominator status
// 2, both with zero fields; otherwise the gcd of |numerator| and the
// denominator divides both, the numerator keeps its sign, status is 0, and
// whole_number flags a reduced denominator of one. Items are classified on
// entry and parked in a two-entry queue, so the input keeps taking beats
// (up to two ahead) while the back end works or the output is stalled. The
// back end handles one item at a time. It runs a binary gcd loop doing one
// shift or subtract per cycle, then two bit-serial restoring divisions on one
// shared divider. Each division loads its operands on a start pulse, runs
// VALUE_WIDTH restoring steps and then raises done. Around these, the back
// end pops the queue, sees the gcd finish and loads the output beat. Every
// subtract is followed by a shift that drops an operand bit, so the number
// of gcd steps stays under 4*VALUE_WIDTH. A refused item skips the gcd and
// the divisions and goes straight to loading its output beat. An accepted
// input beat waits in the queue until the back end is idle and pops it. No
// state survives between items.

module fraction_reducer #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] numerator_i,
  input  logic [VALUE_WIDTH-1:0] denominator_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [VALUE_WIDTH-1:0] reduced_numerator_o,
  output logic [VALUE_WIDTH-2:0] reduced_denominator_o,
  output logic                   whole_number_o
);
  import fr_pkg::*;

  // Queue entry: classification, numerator magnitude, positive denominator
  localparam int unsigned ENT_W = $bits(fr_cls_t) + 2 * VALUE_WIDTH - 1;

  logic                   push_valid;
  logic                   push_ready;
  fr_cls_t                push_cls;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic [VALUE_WIDTH-2:0] push_den;
  logic [ENT_W-1:0]       push_data;

  logic                   pop_valid;
  logic                   pop_ready;
  logic [ENT_W-1:0]       pop_data;
  fr_cls_t                pop_cls;
  logic [VALUE_WIDTH-1:0] pop_mag;
  logic [VALUE_WIDTH-2:0] pop_den;

  status_e                core_status;

  // Front: sign/zero checks and magnitude
  fr_front #(.W(VALUE_WIDTH)) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .num_i        (numerator_i),
    .den_i        (denominator_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .cls_o        (push_cls),
    .mag_o        (push_mag),
    .den_o        (push_den)
  );

  assign push_data = {push_cls, push_mag, push_den};

  // Decoupling queue between classifier and the gcd/divide engine
  fr_fifo #(.DW(ENT_W)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {pop_cls, pop_mag, pop_den} = pop_data;

  // Back: binary gcd, two divisions, registered output beat
  fr_core #(.W(VALUE_WIDTH)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cls_i   (pop_cls),
    .pop_mag_i   (pop_mag),
    .pop_den_i   (pop_den),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (core_status),
    .red_num_o   (reduced_numerator_o),
    .red_den_o   (reduced_denominator_o),
    .whole_o     (whole_number_o)
  );

  assign status_o = core_status;

endmodule
